// ----- rtl/sae_pkg.sv -----
// Shared types, constants and the cumulative letter table for the static-model
// arithmetic encoder. No dependencies; every other file imports this package.
`default_nettype none

package sae_pkg;

  // Default precisions of the coding interval and of the probability table
  localparam int unsigned SAE_PREC_DEF      = 32;
  localparam int unsigned SAE_PROB_BITS_DEF = 24;

  localparam int unsigned CODE_W     = 32;
  localparam int unsigned SYM_BITS   = 5;
  localparam int unsigned NUM_SYM    = 27;
  localparam int unsigned CUM_W      = 33;
  localparam int unsigned FREQ_SCALE = 100000;

  localparam logic [SYM_BITS-1:0] STOP_SYM = 5'd26;

  localparam logic [7:0] CHAR_LC_A = 8'h61;
  localparam logic [7:0] CHAR_LC_Z = 8'h7a;
  localparam logic [7:0] CHAR_UC_A = 8'h41;
  localparam logic [7:0] CHAR_UC_Z = 8'h5a;

  // Cumulative English letter frequencies in units of 0.00001
  localparam logic [16:0] CUM_UNITS [NUM_SYM] = '{
    17'd0,     17'd8167,  17'd9659,  17'd12441, 17'd16694, 17'd29396, 17'd31624,
    17'd33639, 17'd39733, 17'd46699, 17'd46852, 17'd47624, 17'd51649, 17'd54055,
    17'd60804, 17'd68311, 17'd70240, 17'd70335, 17'd76322, 17'd82649, 17'd91705,
    17'd94463, 17'd95441, 17'd97801, 17'd97951, 17'd99925, 17'd99999
  };

  typedef struct packed {
    logic [7:0] symbol_byte;
    logic       end_of_message;
  } in_t;

  typedef struct packed {
    logic [CODE_W-1:0] code_value;
    logic              precision_lost;
  } out_t;

  typedef struct packed {
    logic                is_letter;
    logic [SYM_BITS-1:0] sym;
  } sym_info_t;

  // Round-half-up fixed-point cumulative bound; used at elaboration only
  function automatic logic [CUM_W-1:0] cum_fixed(input int unsigned idx,
                                                 input int unsigned prob_bits);
    logic [63:0] k;
    logic [63:0] num;
    if (idx >= NUM_SYM) begin
      return CUM_W'(64'd1 << prob_bits);
    end
    k   = 64'(CUM_UNITS[idx]);
    num = (k << prob_bits) + 64'(FREQ_SCALE / 2);
    return CUM_W'(num / FREQ_SCALE);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sae_sym_dec.sv -----
// Letter decoder: maps a raw byte to a symbol index, either case.
// Depends on sae_pkg.
`default_nettype none

module sae_sym_dec (
  input  wire logic [7:0]         symbol_byte,
  output sae_pkg::sym_info_t      sym_info
);
  import sae_pkg::*;

  logic       lc;
  logic       uc;
  logic [7:0] lc_off;
  logic [7:0] uc_off;

  assign lc     = (symbol_byte >= CHAR_LC_A) && (symbol_byte <= CHAR_LC_Z);
  assign uc     = (symbol_byte >= CHAR_UC_A) && (symbol_byte <= CHAR_UC_Z);
  assign lc_off = symbol_byte - CHAR_LC_A;
  assign uc_off = symbol_byte - CHAR_UC_A;

  assign sym_info.is_letter = lc | uc;
  assign sym_info.sym       = lc ? lc_off[SYM_BITS-1:0] : uc_off[SYM_BITS-1:0];

endmodule

`default_nettype wire

// ----- rtl/sae_narrow.sv -----
// Interval narrowing datapath: two table multiplies give the sub-interval
// bounds; also forms the stop-symbol midpoint code. Depends on sae_pkg.
`default_nettype none

module sae_narrow #(
  parameter int unsigned PREC      = sae_pkg::SAE_PREC_DEF,
  parameter int unsigned PROB_BITS = sae_pkg::SAE_PROB_BITS_DEF
) (
  input  wire logic [PREC-1:0]             low_i,
  input  wire logic [PREC:0]               range_i,
  input  wire logic [sae_pkg::SYM_BITS-1:0] sym_i,
  input  wire logic                        eom_i,
  output logic      [PREC-1:0]             low_nxt,
  output logic      [PREC:0]               range_nxt,
  output logic                             collapse,
  output logic      [sae_pkg::CODE_W-1:0]  code,
  output logic                             stop_empty
);
  import sae_pkg::*;

  localparam int unsigned RW  = PREC + 1;
  localparam int unsigned CW  = PROB_BITS + 1;
  localparam int unsigned PW  = RW + CW;
  localparam int unsigned XW  = (PREC > CODE_W) ? PREC : CODE_W;
  localparam logic [PREC+1:0] CODE_TOP = {2'b00, {PREC{1'b1}}};

  logic [CW-1:0]       cum_tab [NUM_SYM+1];
  logic [SYM_BITS-1:0] idx_lo;
  logic [SYM_BITS-1:0] idx_hi;
  logic [PW-1:0]       prod_lo;
  logic [PW-1:0]       prod_hi;
  logic [RW-1:0]       lo_off;
  logic [RW-1:0]       hi_off;
  logic [RW-1:0]       stop_w;
  logic [PREC+1:0]     code_full;
  logic [PREC-1:0]     code_sat;
  logic [XW-1:0]       code_ext;

  for (genvar i = 0; i <= NUM_SYM; i++) begin : g_cum
    assign cum_tab[i] = CW'(cum_fixed(i, PROB_BITS));
  end

  // End of message codes the stop symbol through the lower-bound multiplier
  assign idx_lo = eom_i ? STOP_SYM : sym_i;
  assign idx_hi = idx_lo + SYM_BITS'(1);

  assign prod_lo = PW'(range_i) * PW'(cum_tab[idx_lo]);
  assign prod_hi = PW'(range_i) * PW'(cum_tab[idx_hi]);
  assign lo_off  = prod_lo[PROB_BITS +: RW];
  assign hi_off  = prod_hi[PROB_BITS +: RW];

  assign collapse  = hi_off <= lo_off;
  assign low_nxt   = low_i + lo_off[PREC-1:0];
  assign range_nxt = hi_off - lo_off;

  assign stop_w     = range_i - lo_off;
  assign stop_empty = stop_w == '0;
  assign code_full  = (PREC+2)'(low_i) + (PREC+2)'(lo_off) + (PREC+2)'(stop_w >> 1);
  assign code_sat   = (code_full > CODE_TOP) ? {PREC{1'b1}} : code_full[PREC-1:0];
  assign code_ext   = XW'(code_sat);
  assign code       = code_ext[CODE_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/static_model_arith_encoder_top.sv -----
// Top level of the static-model arithmetic encoder: input register, interval
// state, result register. Depends on sae_pkg, sae_sym_dec and sae_narrow.
//
//  channel | ports                           | carries
//  --------+---------------------------------+-------------------------------
//  input   | in_valid, in_ready, in_data     | byte and end-of-message flag
//  result  | out_valid, out_ready, out_data  | code value and precision flag
//
// One item per cycle while no end of message waits on an untaken result; a result
// passes through the input register, then the result register, before it can transfer.
// The rate is set by the interval recurrence: the range that the two table
// multiplies produce for one item is registered and feeds the next item's multiplies.
// Reset (rst_n low, synchronous) restores the unit interval and clears the flag.
// An end-of-message item waits in the input register while the result register
// holds an untaken code; letters and skipped bytes never wait.
`default_nettype none

module static_model_arith_encoder_top #(
  parameter int unsigned PREC      = sae_pkg::SAE_PREC_DEF,
  parameter int unsigned PROB_BITS = sae_pkg::SAE_PROB_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire sae_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output sae_pkg::out_t      out_data
);
  import sae_pkg::*;

  localparam logic [PREC:0] RANGE_FULL = {1'b1, {PREC{1'b0}}};

  // Input register
  logic      in_vld_r;
  logic      in_vld_nxt;
  in_t       in_data_r;

  // Interval state
  logic [PREC-1:0] low_r;
  logic [PREC-1:0] low_nxt;
  logic [PREC:0]   range_r;
  logic [PREC:0]   range_nxt;
  logic            lost_r;
  logic            lost_nxt;

  // Result register
  logic      out_vld_r;
  logic      out_vld_nxt;
  out_t      out_data_r;

  sym_info_t             sym_info;
  logic [PREC-1:0]       nar_low;
  logic [PREC:0]         nar_range;
  logic                  collapse;
  logic [CODE_W-1:0]     code;
  logic                  stop_empty;
  logic                  adv;
  logic                  eom;

  sae_sym_dec u_sym_dec (
    .symbol_byte (in_data_r.symbol_byte),
    .sym_info    (sym_info)
  );

  sae_narrow #(
    .PREC      (PREC),
    .PROB_BITS (PROB_BITS)
  ) u_narrow (
    .low_i      (low_r),
    .range_i    (range_r),
    .sym_i      (sym_info.sym),
    .eom_i      (in_data_r.end_of_message),
    .low_nxt    (nar_low),
    .range_nxt  (nar_range),
    .collapse   (collapse),
    .code       (code),
    .stop_empty (stop_empty)
  );

  // Advance the held item unless it is an end of message facing a full
  // result register that is not being taken this cycle
  assign eom      = in_data_r.end_of_message;
  assign adv      = in_vld_r && (!eom || !out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid && in_ready) begin
      in_vld_nxt = 1'b1;
    end else if (adv) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    low_nxt   = low_r;
    range_nxt = range_r;
    lost_nxt  = lost_r;
    if (adv) begin
      if (eom) begin
        low_nxt   = '0;
        range_nxt = RANGE_FULL;
        lost_nxt  = 1'b0;
      end else if (sym_info.is_letter) begin
        // Hold the interval on collapse and make the loss sticky
        if (collapse) begin
          lost_nxt = 1'b1;
        end else begin
          low_nxt   = nar_low;
          range_nxt = nar_range;
        end
      end
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (adv && eom) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      low_r     <= '0;
      range_r   <= RANGE_FULL;
      lost_r    <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      low_r     <= low_nxt;
      range_r   <= range_nxt;
      lost_r    <= lost_nxt;
    end
  end

  // Payload registers: load on transfer, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
    if (adv && eom) begin
      out_data_r.code_value     <= code;
      out_data_r.precision_lost <= lost_r | stop_empty;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // The interval never shrinks to nothing
  a_range_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    range_r != '0)
    else $error("interval range is zero");

  // The interval stays inside the unit range
  a_interval_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((PREC+2)'(low_r) + (PREC+2)'(range_r)) <= (PREC+2)'(RANGE_FULL))
    else $error("interval exceeds the unit range");

  // An end of message restores the unit interval and clears the flag
  a_eom_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && eom) |=> (range_r == RANGE_FULL) && (low_r == '0) && !lost_r)
    else $error("interval not restored after end of message");

  // A new result is loaded only by an end of message
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(adv && eom))
    else $error("result raised without end of message");

  // A waiting end of message is never dropped while the result is stalled
  a_eom_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && eom && out_vld_r && !out_ready) |=> in_vld_r && $stable(in_data_r))
    else $error("end of message lost under stall");
`endif

endmodule

`default_nettype wire
